// ===== rtl/rgbbr_pkg.sv =====
// Shared types and constants for the RGB LED breathing PWM core.
`timescale 1ns / 1ps
package rgbbr_pkg;

  localparam int unsigned PeriodW   = 32;
  localparam int unsigned OutW      = 32;
  localparam int unsigned ModeW     = 4;
  localparam int unsigned ModeDataW = 8;
  localparam int unsigned DutyWidth = 32;

  localparam logic [PeriodW-1:0] ResetPeriod = 32'd1000000;
  localparam int unsigned RampSteps = 50;
  localparam int unsigned LevelDiv  = 6;
  localparam logic [PeriodW-1:0] ResetLevel1 = PeriodW'(ResetPeriod / LevelDiv);
  localparam logic [PeriodW-1:0] ResetStep   = PeriodW'(ResetPeriod / RampSteps);

  // floor(x / 6) = (x * Div6Magic) >> Div6Shift, exact for 32-bit x
  localparam logic [31:0] Div6Magic  = 32'hAAAA_AAAB;
  localparam int unsigned Div6Shift  = 34;
  // floor(x / 50) = (x * Div50Magic) >> Div50Shift, exact for 32-bit x
  localparam logic [31:0] Div50Magic = 32'h51EB_851F;
  localparam int unsigned Div50Shift = 36;

  localparam logic ActSetMode = 1'b0;
  localparam logic ActTick    = 1'b1;

  localparam logic [ModeW-1:0] ModeOff        = 4'd0;
  localparam logic [ModeW-1:0] ModeRedPulse   = 4'd1;
  localparam logic [ModeW-1:0] ModeGreenPulse = 4'd2;
  localparam logic [ModeW-1:0] ModeBluePulse  = 4'd3;
  localparam logic [ModeW-1:0] ModeBlueLvl1   = 4'd4;
  localparam logic [ModeW-1:0] ModeBlueLvl2   = 4'd5;
  localparam logic [ModeW-1:0] ModeBlueLvl3   = 4'd6;
  localparam logic [ModeW-1:0] ModeWhitePulse = 4'd7;
  localparam logic [ModeW-1:0] ModeWhiteLvl1  = 4'd8;
  localparam logic [ModeW-1:0] ModeWhiteLvl2  = 4'd9;
  localparam logic [ModeW-1:0] ModeWhiteLvl3  = 4'd10;

  typedef struct packed {
    logic             action;
    logic [ModeW-1:0] mode;
  } req_t;

  typedef struct packed {
    logic [PeriodW-1:0] period;
    logic [PeriodW-1:0] level1;
    logic [PeriodW-1:0] step;
  } period_t;

endpackage

// ===== rtl/rgbbr_period_reg.sv =====
// Period register with precomputed level and ramp step quotients.
`timescale 1ns / 1ps
module rgbbr_period_reg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rgbbr_pkg::PeriodW-1:0] cfg_wdata_i,
  output rgbbr_pkg::period_t           cfg_o
);

  localparam int unsigned ProdW = 2 * rgbbr_pkg::PeriodW;

  logic [ProdW-1:0]   prod6, prod50;
  rgbbr_pkg::period_t cfg_d, cfg_q;

  assign prod6  = ProdW'(cfg_wdata_i) * ProdW'(rgbbr_pkg::Div6Magic);
  assign prod50 = ProdW'(cfg_wdata_i) * ProdW'(rgbbr_pkg::Div50Magic);

  always_comb begin
    cfg_d        = cfg_q;
    cfg_d.period = cfg_wdata_i;
    cfg_d.level1 = rgbbr_pkg::PeriodW'(prod6 >> rgbbr_pkg::Div6Shift);
    cfg_d.step   = rgbbr_pkg::PeriodW'(prod50 >> rgbbr_pkg::Div50Shift);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period <= rgbbr_pkg::ResetPeriod;
      cfg_q.level1 <= rgbbr_pkg::ResetLevel1;
      cfg_q.step   <= rgbbr_pkg::ResetStep;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/rgbbr_in_stage.sv =====
// Input register stage for requests.
`timescale 1ns / 1ps
module rgbbr_in_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           in_action_i,
  input  logic [rgbbr_pkg::ModeW-1:0]    in_mode_i,
  output logic                           req_valid_o,
  input  logic                           req_ready_i,
  output rgbbr_pkg::req_t                req_o
);

  logic            vld_q, vld_d;
  rgbbr_pkg::req_t req_q, req_d;
  logic            load;

  assign in_ready_o = !vld_q || req_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = load || (vld_q && !req_ready_i);
    req_d = req_q;
    if (load) begin
      req_d.action = in_action_i;
      req_d.mode   = in_mode_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign req_valid_o = vld_q;
  assign req_o       = req_q;

endmodule

// ===== rtl/rgbbr_engine.sv =====
// Mode state, triangle ramp and channel duty result register.
`timescale 1ns / 1ps
module rgbbr_engine #(
  parameter int unsigned DUTY_WIDTH = rgbbr_pkg::DutyWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rgbbr_pkg::period_t            cfg_i,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  rgbbr_pkg::req_t               req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [3*rgbbr_pkg::OutW-1:0]  out_duty_o
);

  localparam int unsigned DW = DUTY_WIDTH;
  localparam int unsigned AW =
    ((DUTY_WIDTH > rgbbr_pkg::PeriodW) ? DUTY_WIDTH : rgbbr_pkg::PeriodW) + 1;

  logic [rgbbr_pkg::ModeW-1:0] mode_q, mode_d;
  logic [DW-1:0]               ramp_q, ramp_d;
  logic                        rising_q, rising_d;
  logic                        running_q, running_d;
  logic [2:0][DW-1:0]          duty_q, duty_d;
  logic                        out_vld_q;
  logic                        take;

  logic [AW-1:0]      ramp_ext, step_ext, per_ext, sum, ramp_nxt;
  logic               rising_nxt;
  logic [2:0]         pulsed;
  logic               any_pulse;
  logic [32:0]        l1x3;
  logic [DW-1:0]      lvl1, lvl2, lvl3;
  logic [rgbbr_pkg::PeriodW-1:0] l1;

  assign req_ready_o = !out_vld_q || out_ready_i;
  assign take        = req_valid_i && req_ready_o;

  assign l1   = cfg_i.level1;
  assign l1x3 = {1'b0, l1} + {l1, 1'b0};
  assign lvl1 = DW'(l1);
  assign lvl2 = DW'(l1x3[31:0]);
  assign lvl3 = DW'({l1x3[30:0], 1'b0});

  // ramp step as a triangle between zero and the period
  always_comb begin
    ramp_ext   = AW'(ramp_q);
    step_ext   = AW'(cfg_i.step);
    per_ext    = AW'(cfg_i.period);
    sum        = ramp_ext + step_ext;
    ramp_nxt   = ramp_ext;
    rising_nxt = rising_q;
    if (rising_q) begin
      if (sum >= per_ext) begin
        ramp_nxt   = per_ext - step_ext;
        rising_nxt = 1'b0;
      end else begin
        ramp_nxt = sum;
      end
    end else begin
      if (ramp_ext >= step_ext) begin
        ramp_nxt = ramp_ext - step_ext;
      end else begin
        ramp_nxt   = step_ext;
        rising_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    pulsed[0] = (mode_q == rgbbr_pkg::ModeRedPulse)   || (mode_q == rgbbr_pkg::ModeWhitePulse);
    pulsed[1] = (mode_q == rgbbr_pkg::ModeGreenPulse) || (mode_q == rgbbr_pkg::ModeWhitePulse);
    pulsed[2] = (mode_q == rgbbr_pkg::ModeBluePulse)  || (mode_q == rgbbr_pkg::ModeWhitePulse);
    any_pulse = (req_i.mode == rgbbr_pkg::ModeRedPulse)
             || (req_i.mode == rgbbr_pkg::ModeGreenPulse)
             || (req_i.mode == rgbbr_pkg::ModeBluePulse)
             || (req_i.mode == rgbbr_pkg::ModeWhitePulse);
  end

  always_comb begin
    mode_d    = mode_q;
    ramp_d    = ramp_q;
    rising_d  = rising_q;
    running_d = running_q;
    duty_d    = duty_q;
    if (req_i.action == rgbbr_pkg::ActSetMode) begin
      if (req_i.mode != mode_q) begin
        mode_d = req_i.mode;
        duty_d = '0;
        if (req_i.mode <= rgbbr_pkg::ModeWhiteLvl3) begin
          if (any_pulse) begin
            if (!running_q) begin
              running_d = 1'b1;
              ramp_d    = '0;
              rising_d  = 1'b1;
            end
          end else begin
            running_d = 1'b0;
          end
        end
        unique case (req_i.mode)
          rgbbr_pkg::ModeBlueLvl1:  duty_d[2] = lvl1;
          rgbbr_pkg::ModeBlueLvl2:  duty_d[2] = lvl2;
          rgbbr_pkg::ModeBlueLvl3:  duty_d[2] = lvl3;
          rgbbr_pkg::ModeWhiteLvl1: duty_d = {3{lvl1}};
          rgbbr_pkg::ModeWhiteLvl2: duty_d = {3{lvl2}};
          rgbbr_pkg::ModeWhiteLvl3: duty_d = {3{lvl3}};
          default: ;
        endcase
      end
    end else if (running_q) begin
      for (int ch = 0; ch < 3; ch++) begin
        duty_d[ch] = pulsed[ch] ? ramp_q : '0;
      end
      ramp_d   = DW'(ramp_nxt);
      rising_d = rising_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= rgbbr_pkg::ModeOff;
      ramp_q    <= '0;
      rising_q  <= 1'b1;
      running_q <= 1'b0;
      duty_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        mode_q    <= mode_d;
        ramp_q    <= ramp_d;
        rising_q  <= rising_d;
        running_q <= running_d;
        duty_q    <= duty_d;
      end
      out_vld_q <= take || (out_vld_q && !out_ready_i);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_duty_o  = {rgbbr_pkg::OutW'(duty_q[2]),
                        rgbbr_pkg::OutW'(duty_q[1]),
                        rgbbr_pkg::OutW'(duty_q[0])};

  a_tick_stopped_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && req_i.action == rgbbr_pkg::ActTick && !running_q |=> $stable(duty_q))
    else $error("tick with stopped ramp changed duties");

  a_same_mode_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && req_i.action == rgbbr_pkg::ActSetMode && req_i.mode == mode_q
    |=> $stable(duty_q) && $stable(running_q))
    else $error("repeated mode changed state");

  a_off_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && req_i.action == rgbbr_pkg::ActSetMode && req_i.mode == rgbbr_pkg::ModeOff
    && mode_q != rgbbr_pkg::ModeOff |=> duty_q == '0 && !running_q)
    else $error("off mode did not clear outputs and stop ramp");

  a_result_from_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(take))
    else $error("result appeared without a request");

endmodule

// ===== rtl/rgb_led_mode_breathing_pwm_core.sv =====
// Top level of the RGB LED mode / breathing PWM duty core.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one request per beat: tuser = action (0 set mode, 1 ramp
//   tick), tdata[3:0] = mode. Every request yields one result on m_axis,
//   tdata = {blue, green, red} duty, 32 bits each, red in the low bits.
//   cfg_we_i/cfg_wdata_i load the PWM period; write only while idle. The
//   level and ramp-step quotients are formed by reciprocal multiply at the
//   write, so a request may follow the write in the next cycle.
// Path: a request is registered in the input register on acceptance, and its
//   result is then registered in the duty output register.
// Throughput: one request per cycle while m_axis_tready is high; each one
//   is a single pass: input register, ramp/mode update, duty register.
// Reset: mode off, ramp stopped at zero counting up, all duties zero,
//   period 1000000.
// Stall: when m_axis_tready is low the result holds and the input register
//   still takes one more request; s_axis_tready drops once both are full.
module rgb_led_mode_breathing_pwm_core #(
  parameter int unsigned DUTY_WIDTH = rgbbr_pkg::DutyWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rgbbr_pkg::PeriodW-1:0]       cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rgbbr_pkg::ModeDataW-1:0]     s_axis_tdata,  // [3:0] mode
  input  logic                                s_axis_tuser,  // [0] action
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [3*rgbbr_pkg::OutW-1:0]        m_axis_tdata   // red, green, blue duty
);

  rgbbr_pkg::period_t cfg;
  rgbbr_pkg::req_t    req;
  logic               req_valid, req_ready;

  rgbbr_period_reg u_period (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rgbbr_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_mode_i   (s_axis_tdata[rgbbr_pkg::ModeW-1:0]),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  rgbbr_engine #(
    .DUTY_WIDTH (DUTY_WIDTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_duty_o  (m_axis_tdata)
  );

endmodule

// ===== tb/tb_top.sv =====
// Testbench for rgb_led_mode_breathing_pwm_core: directed table + random phases vs. predictor.
`timescale 1ns / 1ps
module tb_top;
  import rgbbr_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int PhaseItems  = 200;
  localparam int NumPhases   = 9;
  localparam int LongHold    = 80;
  localparam int DrainCycles = 6;
  localparam int NumRows     = 25;

  typedef struct packed {
    logic [OutW-1:0] blue;
    logic [OutW-1:0] green;
    logic [OutW-1:0] red;
  } duty_set_t;

  typedef struct {
    logic            act;
    logic [ModeW-1:0] md;
    bit              typed;
    logic [OutW-1:0] red;
    logic [OutW-1:0] green;
    logic [OutW-1:0] blue;
  } mode_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [PeriodW-1:0]     cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [ModeDataW-1:0]   s_axis_tdata;   // [3:0] mode
  logic                   s_axis_tuser;   // [0] action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [3*OutW-1:0]      m_axis_tdata;   // red, green, blue duty

  rgb_led_mode_breathing_pwm_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // predictor state
  logic [PeriodW-1:0] led_period;
  logic [ModeW-1:0]   led_mode;
  logic [OutW-1:0]    ramp_level;
  bit                 ramp_up;
  bit                 ramp_on;
  logic [OutW-1:0]    chan_duty [3];

  duty_set_t expected_duties [$];
  int  fail_count = 0;
  int  cycle_count = 0;
  int  hold_requests;
  bit  rx_idle_on;

  logic [ModeW-1:0] pulse_modes [4] = '{ModeRedPulse, ModeGreenPulse, ModeBluePulse,
                                        ModeWhitePulse};

  mode_row_t mode_rows [NumRows] = '{
    '{ActTick,    ModeOff,        1, '0, '0, '0},
    '{ActSetMode, ModeOff,        1, '0, '0, '0},
    '{ActSetMode, ModeBlueLvl1,   1, '0, '0, ResetLevel1},
    '{ActSetMode, ModeBlueLvl2,   1, '0, '0, 3 * ResetLevel1},
    '{ActSetMode, ModeBlueLvl3,   1, '0, '0, 6 * ResetLevel1},
    '{ActSetMode, ModeWhiteLvl1,  1, ResetLevel1, ResetLevel1, ResetLevel1},
    '{ActSetMode, ModeWhiteLvl2,  1, 3 * ResetLevel1, 3 * ResetLevel1, 3 * ResetLevel1},
    '{ActSetMode, ModeWhiteLvl3,  1, 6 * ResetLevel1, 6 * ResetLevel1, 6 * ResetLevel1},
    '{ActSetMode, ModeWhiteLvl3,  1, 6 * ResetLevel1, 6 * ResetLevel1, 6 * ResetLevel1},
    '{ActTick,    ModeRedPulse,   1, 6 * ResetLevel1, 6 * ResetLevel1, 6 * ResetLevel1},
    '{ActSetMode, ModeRedPulse,   1, '0, '0, '0},
    '{ActTick,    4'hF,           1, '0, '0, '0},
    '{ActTick,    ModeOff,        0, '0, '0, '0},
    '{ActSetMode, ModeWhitePulse, 1, '0, '0, '0},
    '{ActTick,    ModeOff,        0, '0, '0, '0},
    '{ActSetMode, 4'hF,           1, '0, '0, '0},
    '{ActTick,    ModeOff,        1, '0, '0, '0},
    '{ActSetMode, ModeGreenPulse, 1, '0, '0, '0},
    '{ActTick,    ModeWhiteLvl3,  0, '0, '0, '0},
    '{ActSetMode, ModeBlueLvl3,   1, '0, '0, 6 * ResetLevel1},
    '{ActSetMode, ModeBluePulse,  1, '0, '0, '0},
    '{ActTick,    ModeOff,        1, '0, '0, '0},
    '{ActSetMode, 4'hB,           1, '0, '0, '0},
    '{ActSetMode, ModeOff,        1, '0, '0, '0},
    '{ActTick,    ModeOff,        1, '0, '0, '0}
  };

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bit is_pulsed(logic [ModeW-1:0] md, int ch);
    return (int'(md) == int'(ModeRedPulse) + ch) || (md == ModeWhitePulse);
  endfunction

  function automatic duty_set_t predict_duties(logic act, logic [ModeW-1:0] md);
    logic [PeriodW-1:0] lvl1;
    logic [PeriodW-1:0] stp;
    logic [PeriodW-1:0] lvl;
    logic [PeriodW:0]   sum;
    int                 idx;
    duty_set_t          res;
    if (act == ActSetMode) begin
      if (md != led_mode) begin
        led_mode = md;
        for (int ch = 0; ch < 3; ch++) chan_duty[ch] = '0;
        if (md <= ModeWhiteLvl3) begin
          if (is_pulsed(md, 0) || is_pulsed(md, 1) || is_pulsed(md, 2)) begin
            if (!ramp_on) begin
              ramp_on    = 1'b1;
              ramp_level = '0;
              ramp_up    = 1'b1;
            end
          end else begin
            ramp_on = 1'b0;
          end
          lvl1 = led_period / LevelDiv;
          idx  = (md >= ModeWhiteLvl1) ? int'(md - ModeWhiteLvl1) : int'(md - ModeBlueLvl1);
          unique case (idx)
            0:       lvl = lvl1;
            1:       lvl = lvl1 * 3;
            default: lvl = lvl1 * 6;
          endcase
          if (md >= ModeBlueLvl1 && md <= ModeBlueLvl3) begin
            chan_duty[2] = lvl;
          end else if (md >= ModeWhiteLvl1) begin
            for (int ch = 0; ch < 3; ch++) chan_duty[ch] = lvl;
          end
        end
      end
    end else if (ramp_on) begin
      stp = led_period / RampSteps;
      for (int ch = 0; ch < 3; ch++) chan_duty[ch] = is_pulsed(led_mode, ch) ? ramp_level : '0;
      if (ramp_up) begin
        sum = {1'b0, ramp_level} + {1'b0, stp};
        if (sum >= {1'b0, led_period}) begin
          ramp_level = led_period - stp;
          ramp_up    = 1'b0;
        end else begin
          ramp_level = sum[PeriodW-1:0];
        end
      end else begin
        if (ramp_level >= stp) begin
          ramp_level = ramp_level - stp;
        end else begin
          ramp_level = stp;
          ramp_up    = 1'b1;
        end
      end
    end
    res.red   = chan_duty[0];
    res.green = chan_duty[1];
    res.blue  = chan_duty[2];
    return res;
  endfunction

  task automatic send_request(input logic act, input logic [ModeW-1:0] md, input bit gaps);
    int gap;
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(ModeDataW - ModeW){1'b0}}, md};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_period(input logic [PeriodW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    led_period  = value;
  endtask

  // result checker
  always @(posedge clk_i) begin
    duty_set_t want;
    duty_set_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_duties.size() == 0) begin
        $error("result with no request pending: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_duties.pop_front();
        if (got.red !== want.red) begin
          $error("red_duty: expected %0d, got %0d", want.red, got.red);
          fail_count++;
        end
        if (got.green !== want.green) begin
          $error("green_duty: expected %0d, got %0d", want.green, got.green);
          fail_count++;
        end
        if (got.blue !== want.blue) begin
          $error("blue_duty: expected %0d, got %0d", want.blue, got.blue);
          fail_count++;
        end
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk_i) begin
    static int rx_wait = 0;
    static int hold_seen = 0;
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      rx_wait   = LongHold;
    end
    if (rx_wait > 0) begin
      m_axis_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_idle_on) rx_wait = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    duty_set_t          pred;
    logic               act;
    logic [ModeW-1:0]   md;
    logic [PeriodW-1:0] period;
    int                 set_pct;
    bit                 tx_gaps;
    hold_requests = 0;
    rx_idle_on    = 1'b1;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ActSetMode;
    led_period = ResetPeriod;
    led_mode   = ModeOff;
    ramp_level = '0;
    ramp_up    = 1'b1;
    ramp_on    = 1'b0;
    for (int ch = 0; ch < 3; ch++) chan_duty[ch] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      send_request(mode_rows[i].act, mode_rows[i].md, 1'b1);
      pred = predict_duties(mode_rows[i].act, mode_rows[i].md);
      if (mode_rows[i].typed) begin
        pred.red   = mode_rows[i].red;
        pred.green = mode_rows[i].green;
        pred.blue  = mode_rows[i].blue;
      end
      expected_duties.push_back(pred);
    end
    drain_results();

    for (int ph = 0; ph < NumPhases; ph++) begin
      unique case (ph)
        0:       period = 32'd50;
        1:       period = 32'hFFFF_FFFF;
        2:       period = 32'd100;
        3:       period = 32'd49;
        4:       period = $urandom_range(50, 32'hFFFF_FFFF);
        5:       period = $urandom_range(50, 5000);
        6:       period = ResetPeriod;
        7:       period = $urandom();
        default: period = 32'hFFFF_FFFF;
      endcase
      write_period(period);
      set_pct    = (ph % 2 == 0) ? 3 : 15;
      tx_gaps    = (ph != 1 && ph != 5 && ph != 7);
      rx_idle_on <= (ph != 3 && ph != 7);
      if (ph == 1 || ph == 5) hold_requests <= hold_requests + 1;
      for (int i = 0; i < PhaseItems; i++) begin
        if ($urandom_range(0, 99) < set_pct) begin
          act = ActSetMode;
          if ($urandom_range(0, 99) < 60) md = pulse_modes[2'($urandom_range(0, 3))];
          else md = ModeW'($urandom_range(0, 15));
        end else begin
          act = ActTick;
          md  = ModeW'($urandom_range(0, 15));
        end
        send_request(act, md, tx_gaps);
        expected_duties.push_back(predict_duties(act, md));
      end
      // keep the ramp running into the next period setting
      send_request(ActSetMode, ModeWhitePulse, tx_gaps);
      expected_duties.push_back(predict_duties(ActSetMode, ModeWhitePulse));
      drain_results();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
